@@ rtl/pid_line_follow_drive_macros.svh @@
// ----------------------------------------------------------------------------
// PID line follower assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PID_LINE_FOLLOW_DRIVE_MACROS_SVH
`define PID_LINE_FOLLOW_DRIVE_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge
`define PLD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PLD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PLD_ASSERT(lbl, cond, msg)
`define PLD_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/pld_pkg.sv @@
// ----------------------------------------------------------------------------
// PID line follower package
// Widths, register indexes, reciprocal constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

  localparam int POS_W   = 12;
  localparam int REFL_W  = 10;
  localparam int SPD_W   = 8;
  localparam int ERR_W   = 13;
  localparam int DER_W   = 14;
  localparam int SUM_W   = 32;
  localparam int HALF_W  = 15;  // (deriv*3)/2
  localparam int SUMQ_W  = 19;  // |sum|/10000
  localparam int ERRQ_W  = 10;  // |err|/20
  localparam int DIFF_W  = 21;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SETPOINT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED = 2'd1;
  localparam logic [IDX_W-1:0] REG_LOST_THR  = 2'd2;
  localparam logic [IDX_W-1:0] REG_SIDE_THR  = 2'd3;

  localparam logic [POS_W-1:0]  SETPOINT_RST  = 12'd2000;
  localparam logic [SPD_W-1:0]  MAX_SPEED_RST = 8'd60;
  localparam logic [REFL_W-1:0] LOST_THR_RST  = 10'd100;
  localparam logic [REFL_W-1:0] SIDE_THR_RST  = 10'd200;

  // floor(a/10000) = (a * SUM_RECIP) >> SUM_SHIFT, exact for a <= 2^31
  localparam logic [31:0] SUM_RECIP = 32'd3518437209;
  localparam int          SUM_SHIFT = 45;
  // floor(a/20) = (a * ERR_RECIP) >> ERR_SHIFT, exact for a < 2^14
  localparam logic [13:0] ERR_RECIP = 14'd6554;
  localparam int          ERR_SHIFT = 17;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [DER_W-1:0] deriv;
    logic signed [SUM_W-1:0] sum;
    logic                    seg_end;
  } pld_front_t;

endpackage

`default_nettype wire

@@ rtl/pld_if.sv @@
// ----------------------------------------------------------------------------
// PID line follower channel interfaces
// Sample channel (position and reflectance) and drive channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pld_sample_if import pld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic [REFL_W-1:0] reflect_0;
  logic [REFL_W-1:0] reflect_1;
  logic [REFL_W-1:0] reflect_2;
  logic [REFL_W-1:0] reflect_3;
  logic [REFL_W-1:0] reflect_4;

  modport source (output valid, position, reflect_0, reflect_1, reflect_2, reflect_3,
                  reflect_4, input ready);
  modport sink (input valid, position, reflect_0, reflect_1, reflect_2, reflect_3,
                reflect_4, output ready);
endinterface

interface pld_drive_if import pld_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SPD_W-1:0] left_drive;
  logic [SPD_W-1:0] right_drive;
  logic             segment_end;

  modport source (output valid, left_drive, right_drive, segment_end, input ready);
  modport sink (input valid, left_drive, right_drive, segment_end, output ready);
endinterface

`default_nettype wire

@@ rtl/pld_state.sv @@
// ----------------------------------------------------------------------------
// PID line follower loop state
// Error, derivative, saturating integral and segment-end detection.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pid_line_follow_drive_macros.svh"

module pld_state import pld_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [REFL_W-1:0] reflect_0,
  input  wire logic [REFL_W-1:0] reflect_1,
  input  wire logic [REFL_W-1:0] reflect_2,
  input  wire logic [REFL_W-1:0] reflect_3,
  input  wire logic [REFL_W-1:0] reflect_4,
  input  wire logic [POS_W-1:0]  setpoint,
  input  wire logic [REFL_W-1:0] lost_threshold,
  input  wire logic [REFL_W-1:0] side_threshold,
  output pld_front_t             front
);

  logic signed [ERR_W-1:0] previous_error;
  logic signed [SUM_W-1:0] error_sum;

  logic signed [ERR_W-1:0] err;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    lost;
  logic                    side;

  always_comb begin
    err      = $signed({1'b0, position}) - $signed({1'b0, setpoint});
    sum_wide = $signed({error_sum[SUM_W-1], error_sum}) + (SUM_W+1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    lost = (reflect_1 < lost_threshold) && (reflect_2 < lost_threshold)
           && (reflect_3 < lost_threshold);
    side = (reflect_0 > side_threshold) || (reflect_4 > side_threshold);

    front.err     = err;
    front.deriv   = DER_W'(err) - DER_W'(previous_error);
    front.sum     = sum_sat;
    front.seg_end = lost || side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
    end else if (accept) begin
      previous_error <= front.seg_end ? '0 : err;
      error_sum      <= front.seg_end ? '0 : sum_sat;
    end
  end

  `PLD_ASSERT_NEXT(a_seg_clears, accept && front.seg_end, (previous_error == '0) && (error_sum == '0), "loop state not cleared on segment end")
  `PLD_ASSERT_NEXT(a_hold_idle, !accept, $stable(previous_error) && $stable(error_sum), "loop state moved without a transaction")
  `PLD_ASSERT_NEXT(a_sum_sat, accept && !front.seg_end && (error_sum == SUM_MAX) && (err > 0), error_sum == SUM_MAX, "integral wrapped past maximum")

endmodule

`default_nettype wire

@@ rtl/pid_line_follow_drive.sv @@
// ----------------------------------------------------------------------------
// PID line follower differential drive
// Computes wheel speed commands from line position and reflectance readings.
// ----------------------------------------------------------------------------
// Takes one sample set per cycle unless drive back-pressure stalls the pipe,
// and returns one drive transaction per sample via stage 1, 2, 3 and output
// registers. The integral and previous error update in the cycle the sample
// is accepted, so that loop (a 33-bit add with saturation) sets the rate;
// the divisions by 10000 and 20 are reciprocal multiplies in later stages.
// Each stage only stalls when full and blocked, so bubbles are absorbed.
// Configuration writes are expected only while the pipeline is empty.
`default_nettype none
`include "pid_line_follow_drive_macros.svh"

module pid_line_follow_drive import pld_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  pld_sample_if.sink            sample,
  pld_drive_if.source           drive
);

  logic [POS_W-1:0]  setpoint;
  logic [SPD_W-1:0]  max_speed;
  logic [REFL_W-1:0] lost_threshold;
  logic [REFL_W-1:0] side_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= SETPOINT_RST;
      max_speed      <= MAX_SPEED_RST;
      lost_threshold <= LOST_THR_RST;
      side_threshold <= SIDE_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:  setpoint       <= cfg_data[POS_W-1:0];
        REG_MAX_SPEED: max_speed      <= cfg_data[SPD_W-1:0];
        REG_LOST_THR:  lost_threshold <= cfg_data[REFL_W-1:0];
        REG_SIDE_THR:  side_threshold <= cfg_data[REFL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1, v2, v3, vo;
  logic rdy1, rdy2, rdy3, rdyo;
  logic accept;

  assign rdyo   = !vo || drive.ready;
  assign rdy3   = !v3 || rdyo;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;
  assign sample.ready = rdy1;
  assign accept = sample.valid && rdy1;

  pld_front_t front;

  pld_state u_state (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .position       (sample.position),
    .reflect_0      (sample.reflect_0),
    .reflect_1      (sample.reflect_1),
    .reflect_2      (sample.reflect_2),
    .reflect_3      (sample.reflect_3),
    .reflect_4      (sample.reflect_4),
    .setpoint       (setpoint),
    .lost_threshold (lost_threshold),
    .side_threshold (side_threshold),
    .front          (front)
  );

  // stage 1: loop state snapshot
  pld_front_t s1;

  // stage 2: magnitudes and derivative term
  logic [SUM_W-1:0]         s2_sum_mag;
  logic                     s2_sum_neg;
  logic [ERR_W-1:0]         s2_err_mag;
  logic                     s2_err_neg;
  logic signed [HALF_W-1:0] s2_half;
  logic                     s2_seg;

  logic signed [DER_W+1:0]  d3;
  logic signed [DER_W+1:0]  d3_bias;

  always_comb begin
    d3      = (DER_W+2)'(s1.deriv) + ((DER_W+2)'(s1.deriv) <<< 1);
    d3_bias = d3 + (DER_W+2)'({1'b0, d3[DER_W+1]});
  end

  // stage 3: reciprocal products
  logic [SUMQ_W-1:0]        s3_sum_q;
  logic                     s3_sum_neg;
  logic [ERRQ_W-1:0]        s3_err_q;
  logic                     s3_err_neg;
  logic signed [HALF_W-1:0] s3_half;
  logic                     s3_seg;

  logic [2*SUM_W-1:0]       sum_prod;
  logic [ERR_W+13:0]        err_prod;

  assign sum_prod = (2*SUM_W)'(s2_sum_mag) * (2*SUM_W)'(SUM_RECIP);
  assign err_prod = (ERR_W+14)'(s2_err_mag) * (ERR_W+14)'(ERR_RECIP);

  // output stage: combine, clamp, split to wheels
  logic signed [DIFF_W-1:0] sum_term;
  logic signed [DIFF_W-1:0] err_term;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] lim;
  logic signed [DIFF_W-1:0] diff_clamp;
  logic [SPD_W-1:0]         left_next;
  logic [SPD_W-1:0]         right_next;

  always_comb begin
    sum_term = s3_sum_neg ? -$signed(DIFF_W'(s3_sum_q)) : $signed(DIFF_W'(s3_sum_q));
    err_term = s3_err_neg ? -$signed(DIFF_W'(s3_err_q)) : $signed(DIFF_W'(s3_err_q));
    diff     = sum_term + err_term + DIFF_W'(s3_half);
    lim      = $signed(DIFF_W'(max_speed));
    if (diff > lim) begin
      diff_clamp = lim;
    end else if (diff < -lim) begin
      diff_clamp = -lim;
    end else begin
      diff_clamp = diff;
    end
    left_next  = max_speed;
    right_next = max_speed;
    if (diff_clamp < 0) begin
      left_next = SPD_W'(lim + diff_clamp);
    end else begin
      right_next = SPD_W'(lim - diff_clamp);
    end
  end

  logic [SPD_W-1:0] left_drive;
  logic [SPD_W-1:0] right_drive;
  logic             segment_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) v1 <= sample.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdyo) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= front;
    end
    if (rdy2 && v1) begin
      s2_sum_neg <= s1.sum[SUM_W-1];
      s2_sum_mag <= s1.sum[SUM_W-1] ? (~s1.sum + 1'b1) : s1.sum;
      s2_err_neg <= s1.err[ERR_W-1];
      s2_err_mag <= s1.err[ERR_W-1] ? (~s1.err + 1'b1) : s1.err;
      s2_half    <= HALF_W'(d3_bias >>> 1);
      s2_seg     <= s1.seg_end;
    end
    if (rdy3 && v2) begin
      s3_sum_q   <= sum_prod[SUM_SHIFT +: SUMQ_W];
      s3_sum_neg <= s2_sum_neg;
      s3_err_q   <= err_prod[ERR_SHIFT +: ERRQ_W];
      s3_err_neg <= s2_err_neg;
      s3_half    <= s2_half;
      s3_seg     <= s2_seg;
    end
    if (rdyo && v3) begin
      left_drive  <= left_next;
      right_drive <= right_next;
      segment_end <= s3_seg;
    end
  end

  assign drive.valid       = vo;
  assign drive.left_drive  = left_drive;
  assign drive.right_drive = right_drive;
  assign drive.segment_end = segment_end;

  `PLD_ASSERT_IMPL(a_one_wheel_full, vo, (left_drive == max_speed) || (right_drive == max_speed), "neither wheel at base speed")
  `PLD_ASSERT_IMPL(a_drive_bounded, vo, (left_drive <= max_speed) && (right_drive <= max_speed), "wheel command above base speed")
  `PLD_ASSERT_NEXT(a_stage1_hold, v1 && !rdy2, v1 && $stable(s1), "stalled stage 1 lost its contents")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// PID line follower drive testbench
// Drives sample transactions through the sample channel and checks each
// drive transaction against an in-bench PID predictor: directed corners,
// then random sensor traffic under several register settings and
// handshake idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import pld_pkg::*; ();

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [REFL_W-1:0] r0;
    logic [REFL_W-1:0] r1;
    logic [REFL_W-1:0] r2;
    logic [REFL_W-1:0] r3;
    logic [REFL_W-1:0] r4;
  } sensor_set_t;

  typedef struct packed {
    logic [SPD_W-1:0] left_drive;
    logic [SPD_W-1:0] right_drive;
    logic             segment_end;
  } wheel_cmd_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pld_sample_if sample ();
  pld_drive_if  drive ();

  pid_line_follow_drive u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .drive     (drive)
  );

  // register shadows and loop state of the predictor
  logic [POS_W-1:0]  setpoint_cfg;
  logic [SPD_W-1:0]  speed_cfg;
  logic [REFL_W-1:0] lost_cfg;
  logic [REFL_W-1:0] side_cfg;
  longint            last_error;
  longint            error_integral;

  sensor_set_t pending_samples[$];
  wheel_cmd_t  expected_cmds[$];
  sensor_set_t outgoing;
  sensor_set_t taken;
  wheel_cmd_t  want;

  int  send_idle_pct;
  int  sink_stall_pct;
  bit  hold_sender;
  int  mismatches;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic wheel_cmd_t steer(input sensor_set_t s);
    longint     err;
    longint     deriv;
    longint     acc;
    longint     diff;
    longint     lim;
    longint     lw;
    longint     rw;
    logic       seg;
    wheel_cmd_t cmd;
    err = longint'(s.position);
    err = err - longint'(setpoint_cfg);
    deriv = err - last_error;
    acc = error_integral + err;
    if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
    if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
    error_integral = acc;
    last_error = err;
    diff = err / 20 + acc / 10000 + (deriv * 3) / 2;
    lim = longint'(speed_cfg);
    if (diff > lim) diff = lim;
    if (diff < -lim) diff = -lim;
    lw = lim;
    rw = lim;
    if (diff < 0) lw = lim + diff;
    else rw = lim - diff;
    seg = (s.r1 < lost_cfg && s.r2 < lost_cfg && s.r3 < lost_cfg) ||
          s.r0 > side_cfg || s.r4 > side_cfg;
    if (seg) begin
      last_error = 0;
      error_integral = 0;
    end
    cmd.left_drive = lw[SPD_W-1:0];
    cmd.right_drive = rw[SPD_W-1:0];
    cmd.segment_end = seg;
    return cmd;
  endfunction

  // mostly a tracked line, some lost line / intersection, some raw noise
  function automatic sensor_set_t random_sample();
    sensor_set_t s;
    int unsigned kind;
    kind = $urandom_range(99);
    s.position = ($urandom_range(9) == 0) ? POS_W'($urandom_range(4095))
                                          : POS_W'($urandom_range(4000));
    s.r0 = REFL_W'($urandom_range(side_cfg));
    s.r4 = REFL_W'($urandom_range(side_cfg));
    s.r1 = REFL_W'($urandom_range(1023));
    s.r2 = REFL_W'($urandom_range(1023, lost_cfg));
    s.r3 = REFL_W'($urandom_range(1023));
    if (kind >= 85) begin
      s.r0 = REFL_W'($urandom_range(1023));
      s.r1 = REFL_W'($urandom_range(1023));
      s.r2 = REFL_W'($urandom_range(1023));
      s.r3 = REFL_W'($urandom_range(1023));
      s.r4 = REFL_W'($urandom_range(1023));
    end else if (kind >= 78 && lost_cfg != 0) begin
      s.r1 = REFL_W'($urandom_range(lost_cfg - 1));
      s.r2 = REFL_W'($urandom_range(lost_cfg - 1));
      s.r3 = REFL_W'($urandom_range(lost_cfg - 1));
    end else if (kind >= 70 && side_cfg != 10'h3FF) begin
      if (kind[0]) s.r0 = REFL_W'($urandom_range(1023, side_cfg + 1));
      else s.r4 = REFL_W'($urandom_range(1023, side_cfg + 1));
    end
    return s;
  endfunction

  task automatic flag_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want_v, got_v, $time);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
    end else if (!sample.valid || sample.ready) begin
      if (!hold_sender && pending_samples.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        outgoing = pending_samples.pop_front();
        sample.valid     <= 1'b1;
        sample.position  <= outgoing.position;
        sample.reflect_0 <= outgoing.r0;
        sample.reflect_1 <= outgoing.r1;
        sample.reflect_2 <= outgoing.r2;
        sample.reflect_3 <= outgoing.r3;
        sample.reflect_4 <= outgoing.r4;
      end else begin
        sample.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    drive.ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
  end

  // predict on every accepted sample transaction
  always @(posedge clk) begin
    if (!rst && sample.valid && sample.ready) begin
      taken.position = sample.position;
      taken.r0 = sample.reflect_0;
      taken.r1 = sample.reflect_1;
      taken.r2 = sample.reflect_2;
      taken.r3 = sample.reflect_3;
      taken.r4 = sample.reflect_4;
      expected_cmds.push_back(steer(taken));
    end
  end

  // check every accepted drive transaction
  always @(posedge clk) begin
    if (!rst && drive.valid && drive.ready) begin
      if (expected_cmds.size() == 0) begin
        flag_mismatch("unexpected drive transaction, left_drive", -1,
                      int'(drive.left_drive));
      end else begin
        want = expected_cmds.pop_front();
        if (drive.left_drive !== want.left_drive)
          flag_mismatch("left_drive", int'(want.left_drive), int'(drive.left_drive));
        if (drive.right_drive !== want.right_drive)
          flag_mismatch("right_drive", int'(want.right_drive), int'(drive.right_drive));
        if (drive.segment_end !== want.segment_end)
          flag_mismatch("segment_end", int'(want.segment_end), int'(drive.segment_end));
      end
    end
  end

  task automatic queue_sample(input int pos, input int a, input int b, input int c,
                              input int d, input int e);
    sensor_set_t s;
    s.position = POS_W'(pos);
    s.r0 = REFL_W'(a);
    s.r1 = REFL_W'(b);
    s.r2 = REFL_W'(c);
    s.r3 = REFL_W'(d);
    s.r4 = REFL_W'(e);
    pending_samples.push_back(s);
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || sample.valid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SETPOINT:  setpoint_cfg = val[POS_W-1:0];
      REG_MAX_SPEED: speed_cfg = val[SPD_W-1:0];
      REG_LOST_THR:  lost_cfg = val[REFL_W-1:0];
      REG_SIDE_THR:  side_cfg = val[REFL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int sp, input int spd, input int lost, input int side);
    write_reg(REG_SETPOINT, CFG_W'(sp));
    write_reg(REG_MAX_SPEED, CFG_W'(spd));
    write_reg(REG_LOST_THR, CFG_W'(lost));
    write_reg(REG_SIDE_THR, CFG_W'(side));
  endtask

  task automatic run_random(input int count, input bit pause_midway);
    repeat (count) pending_samples.push_back(random_sample());
    if (pause_midway) begin
      while (pending_samples.size() > count / 2) @(posedge clk);
      hold_sender <= 1'b1;
      while (sample.valid || expected_cmds.size() != 0) @(posedge clk);
      hold_sender <= 1'b0;
    end
    settle();
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    sink_stall_pct <= stall_pct;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SETPOINT;
    cfg_data = '0;
    sample.valid = 1'b0;
    sample.position = '0;
    sample.reflect_0 = '0;
    sample.reflect_1 = '0;
    sample.reflect_2 = '0;
    sample.reflect_3 = '0;
    sample.reflect_4 = '0;
    drive.ready = 1'b0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    hold_sender = 1'b0;
    mismatches = 0;
    setpoint_cfg = SETPOINT_RST;
    speed_cfg = MAX_SPEED_RST;
    lost_cfg = LOST_THR_RST;
    side_cfg = SIDE_THR_RST;
    last_error = 0;
    error_integral = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corners at reset settings
    queue_sample(2000, 0, 500, 900, 500, 0);
    queue_sample(0, 0, 300, 50, 50, 0);
    queue_sample(4000, 0, 50, 50, 300, 0);
    queue_sample(4095, 0, 1023, 1023, 1023, 0);
    queue_sample(0, 0, 600, 600, 600, 0);
    queue_sample(2500, 0, 99, 99, 99, 0);       // line lost
    queue_sample(2500, 0, 100, 100, 100, 0);    // right at the lost level
    queue_sample(1500, 200, 400, 400, 400, 0);  // outer at the side level
    queue_sample(1500, 201, 400, 400, 400, 0);  // left intersection
    queue_sample(2600, 0, 400, 400, 400, 201);  // right intersection
    queue_sample(2600, 0, 400, 400, 400, 200);
    queue_sample(2000, 1023, 1023, 1023, 1023, 1023);
    queue_sample(2000, 0, 0, 0, 0, 0);
    queue_sample(12'hAAA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155);
    queue_sample(12'h555, 10'h0AA, 10'h2AA, 10'h155, 10'h2AA, 10'h0AA);
    repeat (5) queue_sample(4000, 0, 500, 800, 500, 0);  // wind up integral
    repeat (3) queue_sample(0, 0, 500, 800, 500, 0);
    queue_sample(1999, 0, 600, 600, 600, 0);
    queue_sample(2001, 0, 600, 600, 600, 0);
    settle();

    // random traffic under varied settings and idling
    set_regs(2000, 128, 500, 700);
    run_random(450, 1'b0);

    set_regs(0, 255, 1023, 0);
    set_idling(74, 0);
    run_random(450, 1'b1);

    set_regs(4095, 0, 0, 1023);
    set_idling(0, 74);
    run_random(450, 1'b0);

    set_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
             $urandom_range(4095));
    set_idling(38, 38);
    run_random(450, 1'b0);

    settle();
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("PASS pid_line_follow_drive");
    end else begin
      $display("FAIL pid_line_follow_drive");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("FAIL pid_line_follow_drive");
    $finish;
  end

endmodule

`default_nettype wire
